// File: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, constants and helpers shared by the status LED pattern engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic        comm_activity;
        logic [1:0]  fault_code;
        logic        any_output_active;
        logic        coil_one;
        logic        coil_two;
        logic        coil_three;
    } step_t;

    typedef struct packed {
        logic led_power;
        logic led_output;
        logic led_current;
        logic led_comm;
    } led_t;

    localparam logic [1:0] REG_DIAG_MODE    = 2'd0;
    localparam logic [1:0] REG_NORMAL_SOLID = 2'd1;
    localparam logic [1:0] REG_IDLE_THRESH  = 2'd2;
    localparam logic [1:0] REG_PULSE_LENGTH = 2'd3;

    localparam logic [1:0] FAULT_NORMAL      = 2'd0;
    localparam logic [1:0] FAULT_OVERCURRENT = 2'd1;
    localparam logic [1:0] FAULT_SENSOR      = 2'd2;

    localparam logic [2:0]  NO_FAULT_SEEN = 3'd4;
    localparam logic [6:0]  STEP_CAP      = 7'd100;
    localparam logic [10:0] PERIOD_MS     = 11'd1000;
    localparam logic [9:0]  HALF_PERIOD   = 10'd500;
    localparam logic [8:0]  OC_PERIOD     = 9'd250;
    localparam logic [7:0]  OC_HALF       = 8'd125;
    localparam logic [9:0]  SENS_ON1_END  = 10'd125;
    localparam logic [9:0]  SENS_ON2_BEG  = 10'd250;
    localparam logic [9:0]  SENS_ON2_END  = 10'd375;

    localparam logic [15:0] IDLE_THRESH_RESET  = 16'd3000;
    localparam logic [9:0]  PULSE_LENGTH_RESET = 10'd30;

    // Remainder of a 16-bit value by 1000. The quotient estimate v*65/2^16
    // is low by at most one, so a single correction step finishes the job.
    function automatic logic [9:0] mod_1000(input logic [15:0] v);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [16:0] qk;
        logic [10:0] r;
        prod = {1'b0, v, 6'b0} + {7'b0, v};
        q    = prod[22:16];
        qk   = {q, 10'b0} - {6'b0, q, 4'b0} - {7'b0, q, 3'b0};
        r    = v[10:0] - qk[10:0];
        if (r >= PERIOD_MS)
        begin
            r = r - PERIOD_MS;
        end
        return r[9:0];
    endfunction

endpackage

// File: sv/sle_stream_if.sv
// ----------------------------------------------------------------------------
// sle_stream_if
// Valid/ready channel that carries one payload per transaction.
// ----------------------------------------------------------------------------
interface sle_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/status_led_pattern_engine_unit.sv
// ----------------------------------------------------------------------------
// status_led_pattern_engine_unit
// Turns time steps with activity, fault and coil status into LED states.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 registers the step, the output register its result.
// Throughput: one step per cycle unless leds.ready stalls the output.
// Reset: asynchronous, active low; config and state registers take their reset
// values, the data registers are not reset, and the pipeline empties.
// ----------------------------------------------------------------------------
module status_led_pattern_engine_unit #(
    parameter int IDLE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    sle_stream_if.sink            steps,
    sle_stream_if.source          leds
);
    import sle_pkg::*;

    localparam logic [IDLE_WIDTH-1:0] IDLE_MAX     = '1;
    localparam logic [9:0]            IDLE_MAX_MOD = 10'(IDLE_MAX % PERIOD_MS);

    logic        diag_mode_reg;
    logic        normal_solid_reg;
    logic [15:0] idle_thresh_reg;
    logic [9:0]  thresh_mod_reg;
    logic [9:0]  pulse_length_reg;

    logic        s1_valid_reg;
    step_t       s1_data_reg;
    logic [9:0]  s1_elmod_reg;

    logic        out_valid_reg;
    led_t        out_data_reg;

    logic [9:0]            pulse_left_reg, pulse_left_next;
    logic [IDLE_WIDTH-1:0] idle_time_reg, idle_time_next;
    logic [9:0]            idle_mod_reg, idle_mod_next;
    logic [2:0]            fault_seen_reg, fault_seen_next;
    logic [9:0]            phase_normal_reg, phase_normal_next;
    logic [7:0]            phase_oc_reg, phase_oc_next;
    logic [9:0]            phase_sensor_reg, phase_sensor_next;
    logic [2:0]            led_held_reg, led_held_next;
    logic                  fresh_reg, fresh_next;
    led_t                  result;

    logic out_free;
    logic s1_adv;
    logic in_take;

    assign out_free    = !out_valid_reg || leds.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign steps.ready = !s1_valid_reg || out_free;
    assign in_take     = steps.valid && steps.ready;
    assign leds.valid  = out_valid_reg;
    assign leds.data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_mode_reg    <= 1'b1;
            normal_solid_reg <= 1'b1;
            idle_thresh_reg  <= IDLE_THRESH_RESET;
            thresh_mod_reg   <= mod_1000(IDLE_THRESH_RESET);
            pulse_length_reg <= PULSE_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIAG_MODE:    diag_mode_reg    <= cfg_data[0];
                REG_NORMAL_SOLID: normal_solid_reg <= cfg_data[0];
                REG_IDLE_THRESH:
                begin
                    idle_thresh_reg <= cfg_data;
                    thresh_mod_reg  <= mod_1000(cfg_data);
                end
                REG_PULSE_LENGTH: pulse_length_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (steps.ready)
            begin
                s1_valid_reg <= steps.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= steps.data;
            s1_elmod_reg <= mod_1000(steps.data.elapsed_ms);
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_left_reg   <= '0;
            idle_time_reg    <= '0;
            idle_mod_reg     <= '0;
            fault_seen_reg   <= NO_FAULT_SEEN;
            phase_normal_reg <= '0;
            phase_oc_reg     <= '0;
            phase_sensor_reg <= '0;
            led_held_reg     <= '0;
            fresh_reg        <= 1'b1;
        end
        else if (s1_adv)
        begin
            pulse_left_reg   <= pulse_left_next;
            idle_time_reg    <= idle_time_next;
            idle_mod_reg     <= idle_mod_next;
            fault_seen_reg   <= fault_seen_next;
            phase_normal_reg <= phase_normal_next;
            phase_oc_reg     <= phase_oc_next;
            phase_sensor_reg <= phase_sensor_next;
            led_held_reg     <= led_held_next;
            fresh_reg        <= fresh_next;
        end
    end

    always_comb
    begin
        logic [15:0]           el;
        logic [6:0]            step;
        logic [IDLE_WIDTH:0]   idle_sum;
        logic [10:0]           mod_sum;
        logic [10:0]           pn_sum;
        logic [8:0]            po_sum;
        logic [10:0]           ps_sum;
        logic [9:0]            comm_phase;
        logic                  cur;
        logic                  comm;
        logic [2:0]            leds_val;

        el = s1_data_reg.elapsed_ms;
        step = (el > {9'b0, STEP_CAP}) ? STEP_CAP : el[6:0];

        pulse_left_next   = pulse_left_reg;
        idle_time_next    = idle_time_reg;
        idle_mod_next     = idle_mod_reg;
        fault_seen_next   = fault_seen_reg;
        phase_normal_next = phase_normal_reg;
        phase_oc_next     = phase_oc_reg;
        phase_sensor_next = phase_sensor_reg;
        led_held_next     = led_held_reg;
        fresh_next        = fresh_reg;
        cur               = 1'b1;
        comm              = 1'b0;
        pn_sum            = '0;
        po_sum            = '0;
        ps_sum            = '0;
        comm_phase        = '0;

        if (s1_data_reg.comm_activity)
        begin
            pulse_left_next = pulse_length_reg;
            idle_time_next  = '0;
            idle_mod_next   = '0;
        end

        idle_sum = {1'b0, idle_time_next} + (IDLE_WIDTH + 1)'(el);
        mod_sum  = {1'b0, idle_mod_next} + {1'b0, s1_elmod_reg};
        if (mod_sum >= PERIOD_MS)
        begin
            mod_sum = mod_sum - PERIOD_MS;
        end

        if (el == '0)
        begin
            if (fresh_reg)
            begin
                leds_val = diag_mode_reg ? 3'b000 : 3'b010;
            end
            else
            begin
                leds_val = led_held_reg;
            end
        end
        else
        begin
            if (idle_sum[IDLE_WIDTH])
            begin
                idle_time_next = IDLE_MAX;
                idle_mod_next  = IDLE_MAX_MOD;
            end
            else
            begin
                idle_time_next = idle_sum[IDLE_WIDTH-1:0];
                idle_mod_next  = mod_sum[9:0];
            end
            pulse_left_next = (pulse_left_next <= {3'b0, step}) ? '0
                              : pulse_left_next - {3'b0, step};

            if (diag_mode_reg)
            begin
                leds_val = {s1_data_reg.coil_three, s1_data_reg.coil_two,
                            s1_data_reg.coil_one};
            end
            else
            begin
                if ({1'b0, s1_data_reg.fault_code} != fault_seen_reg)
                begin
                    phase_normal_next = '0;
                    phase_oc_next     = '0;
                    phase_sensor_next = '0;
                end
                fault_seen_next = {1'b0, s1_data_reg.fault_code};

                case (s1_data_reg.fault_code)
                    FAULT_NORMAL:
                    begin
                        if (!normal_solid_reg)
                        begin
                            pn_sum = {1'b0, phase_normal_next} + {4'b0, step};
                            if (pn_sum >= PERIOD_MS)
                            begin
                                pn_sum = pn_sum - PERIOD_MS;
                            end
                            phase_normal_next = pn_sum[9:0];
                            cur = phase_normal_next < HALF_PERIOD;
                        end
                    end
                    FAULT_OVERCURRENT:
                    begin
                        po_sum = {1'b0, phase_oc_next} + {2'b0, step};
                        if (po_sum >= OC_PERIOD)
                        begin
                            po_sum = po_sum - OC_PERIOD;
                        end
                        phase_oc_next = po_sum[7:0];
                        cur = phase_oc_next < OC_HALF;
                    end
                    FAULT_SENSOR:
                    begin
                        ps_sum = {1'b0, phase_sensor_next} + {4'b0, step};
                        if (ps_sum >= PERIOD_MS)
                        begin
                            ps_sum = ps_sum - PERIOD_MS;
                        end
                        phase_sensor_next = ps_sum[9:0];
                        cur = (phase_sensor_next < SENS_ON1_END)
                              || ((phase_sensor_next >= SENS_ON2_BEG)
                                  && (phase_sensor_next < SENS_ON2_END));
                    end
                    default: cur = 1'b1;
                endcase

                if (pulse_left_next != '0)
                begin
                    comm = 1'b1;
                end
                else if (idle_time_next > IDLE_WIDTH'(idle_thresh_reg))
                begin
                    if (idle_mod_next >= thresh_mod_reg)
                    begin
                        comm_phase = idle_mod_next - thresh_mod_reg;
                    end
                    else
                    begin
                        comm_phase = idle_mod_next + PERIOD_MS[9:0] - thresh_mod_reg;
                    end
                    comm = comm_phase < HALF_PERIOD;
                end

                leds_val = {comm, cur, s1_data_reg.any_output_active};
            end
            led_held_next = leds_val;
            fresh_next    = 1'b0;
        end

        result.led_power   = 1'b1;
        result.led_output  = leds_val[0];
        result.led_current = leds_val[1];
        result.led_comm    = leds_val[2];
    end

endmodule
